@@ hdl/tgs_pkg.sv @@
// Shared types and constants for the trilinear grid splat block.
// No dependencies; tgs_if, tgs_norm, the top module and the testbench use it.
package tgs_pkg;

  localparam int IDX_W  = 5;
  localparam int FRAC_W = 16;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 48;
  localparam int WGT_W  = 40;
  localparam int NORM_W = 32;

  localparam logic FUNC_SPLAT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLAT,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_NORM,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum;
    logic [WGT_W-1:0]        wgt;
  } norm_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [NORM_W-1:0] q;
  } norm_rsp_t;

  typedef struct packed {
    logic                     status;
    logic signed [SUM_W-1:0]  cell_sum;
    logic [WGT_W-1:0]         cell_weight;
    logic signed [NORM_W-1:0] normalized;
  } result_t;

endpackage

@@ hdl/tgs_if.sv @@
// Valid/ready channel interfaces for the splat block input and result.
// Depends on tgs_pkg for field widths.
interface tgs_in_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [tgs_pkg::IDX_W-1:0]        cell_x;
  logic [tgs_pkg::IDX_W-1:0]        cell_y;
  logic [tgs_pkg::IDX_W-1:0]        cell_z;
  logic [tgs_pkg::FRAC_W-1:0]       frac_x;
  logic [tgs_pkg::FRAC_W-1:0]       frac_y;
  logic [tgs_pkg::FRAC_W-1:0]       frac_z;
  logic signed [tgs_pkg::VAL_W-1:0] particle_value;

  modport source (output valid, func, cell_x, cell_y, cell_z, frac_x, frac_y, frac_z,
                  particle_value, input ready);
  modport sink   (input valid, func, cell_x, cell_y, cell_z, frac_x, frac_y, frac_z,
                  particle_value, output ready);
endinterface

interface tgs_out_if;
  logic                              valid;
  logic                              ready;
  logic                              status;
  logic signed [tgs_pkg::SUM_W-1:0]  cell_sum;
  logic [tgs_pkg::WGT_W-1:0]         cell_weight;
  logic signed [tgs_pkg::NORM_W-1:0] normalized;

  modport source (output valid, status, cell_sum, cell_weight, normalized, input ready);
  modport sink   (input valid, status, cell_sum, cell_weight, normalized, output ready);
endinterface

@@ hdl/tgs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/tgs_norm.sv @@
// Normalizer: (|sum| << 16) / weight by restoring division, one quotient bit
// per cycle, signed and saturated to Q15.16. Depends on tgs_pkg.
module tgs_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  tgs_pkg::norm_req_t  req,
  output tgs_pkg::norm_rsp_t  rsp
);
  import tgs_pkg::*;

  localparam int QW = 33;

  logic              busy_r;
  logic [5:0]        cnt_r;
  logic [63:0]       rem_r;
  logic [71:0]       dsh_r;
  logic [QW-1:0]     q_r;
  logic              neg_r;
  logic              fin_r;
  logic              sat_r;
  logic              zero_r;
  logic              done_r;
  logic [NORM_W-1:0] res_r;

  logic [SUM_W-1:0]  mag;
  logic [63:0]       num;
  logic              ovf;
  logic              take;
  logic [QW-1:0]     q_nxt;

  always_comb begin
    mag  = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);
    num  = {mag, 16'b0};
    ovf  = {9'b0, num} >= {req.wgt, 33'b0};
    take = {8'b0, rem_r} >= dsh_r;
    q_nxt = {q_r[QW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (req.start) begin
        neg_r  <= req.sum[SUM_W-1];
        zero_r <= (req.sum == '0);
        sat_r  <= ovf;
        rem_r  <= num;
        dsh_r  <= {req.wgt, 32'b0};
        q_r    <= '0;
        cnt_r  <= 6'(QW - 1);
        if (req.sum == '0 || ovf) begin
          fin_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (take) begin
          rem_r <= rem_r - dsh_r[63:0];
        end
        dsh_r <= dsh_r >> 1;
        q_r   <= q_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
      if (fin_r) begin
        done_r <= 1'b1;
        if (zero_r) begin
          res_r <= '0;
        end else if (neg_r) begin
          res_r <= (sat_r || q_r >= QW'(33'h080000000)) ? 32'h80000000
                                                      : NORM_W'(-q_r[NORM_W-1:0]);
        end else begin
          res_r <= (sat_r || q_r > QW'(33'h07FFFFFFF)) ? 32'h7FFFFFFF
                                                     : q_r[NORM_W-1:0];
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = res_r;

endmodule

@@ hdl/trilinear_grid_splat_top.sv @@
// Trilinear grid splat: a splat makes 8 corner read-modify-writes through a
// 4-stage weight pipe, one corner a cycle; a read passes the stored sum and weight
// to a bit-serial divider, which is skipped when the sum is zero or the ratio
// saturates; a dropped item goes straight to its result. The next input is taken
// only after the result is loaded, so one item at a time. After reset a clearing
// pass writes zero to all GRID_X*GRID_Y*GRID_Z cells, one a cycle, before the
// first transfer is taken. Depends on tgs_pkg, tgs_if, tgs_ram, tgs_norm.
module trilinear_grid_splat_top #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input logic       clk,
  input logic       rst_n,
  tgs_in_if.sink    in_ch,
  tgs_out_if.source out_ch
);
  import tgs_pkg::*;

  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = $clog2(CELLS);

  // Linear cell address (z * GRID_Y + y) * GRID_X + x; constant multiplies.
  function automatic logic [AW-1:0] cell_addr(input logic [IDX_W:0] x,
                                               input logic [IDX_W:0] y,
                                               input logic [IDX_W:0] z);
    logic [31:0] a;
    a = (32'(z) * 32'(GRID_Y) + 32'(y)) * 32'(GRID_X) + 32'(x);
    return a[AW-1:0];
  endfunction

  state_t state_r, state_nxt;

  // Latched item
  logic [IDX_W-1:0]        x_r, y_r, z_r;
  logic [FRAC_W-1:0]       fx_r, fy_r, fz_r;
  logic signed [VAL_W-1:0] val_r;
  logic [AW-1:0]           rd_idx_r;

  logic [AW-1:0] clr_r;
  logic [3:0]    cnt_r;
  result_t       res_r;
  result_t       out_r;
  logic          out_valid_r;

  // Corner pipe: factors, triple product, rounded weight, contribution
  logic          v1_r, v2_r, v3_r, v4_r;
  logic [AW-1:0] a1_r, a2_r, a3_r, a4_r;
  logic [33:0]   m1_r;
  logic [16:0]   az_r;
  logic [48:0]   m2_r;
  logic [16:0]   w3_r, w4_r;
  logic signed [49:0] prod4_r;

  logic accept, issue, load_out, oob_rd, oob_sp;
  logic [16:0] ax, ay, az;
  logic [48:0] m2_rnd;

  // Memories
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [SUM_W-1:0] vwdata, vrdata;
  logic [WGT_W-1:0] wwdata, wrdata;

  logic signed [50:0] contrib_full;
  logic signed [49:0] vsum;
  logic [WGT_W:0]     wsum;

  norm_req_t nreq;
  norm_rsp_t nrsp;

  assign accept   = in_ch.valid && in_ch.ready;
  assign issue    = (state_r == ST_SPLAT) && (cnt_r < 4'd8);
  assign load_out = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);

  always_comb begin
    oob_rd = ({4'b0, in_ch.cell_x} >= 9'(GRID_X)) || ({4'b0, in_ch.cell_y} >= 9'(GRID_Y)) ||
             ({4'b0, in_ch.cell_z} >= 9'(GRID_Z));
    oob_sp = ({4'b0, in_ch.cell_x} + 9'd1 >= 9'(GRID_X)) ||
             ({4'b0, in_ch.cell_y} + 9'd1 >= 9'(GRID_Y)) ||
             ({4'b0, in_ch.cell_z} + 9'd1 >= 9'(GRID_Z));
  end

  // Next state and handshake outputs
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == AW'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.func == FUNC_READ) begin
            state_nxt = oob_rd ? ST_FINISH : ST_RD_ADDR;
          end else begin
            state_nxt = oob_sp ? ST_FINISH : ST_SPLAT;
          end
        end
      end
      ST_SPLAT: begin
        if (cnt_r == 4'd8 && !v1_r && !v2_r && !v3_r && !v4_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_RD_ADDR: state_nxt = ST_RD_DATA;
      ST_RD_DATA: state_nxt = ST_NORM;
      ST_NORM: begin
        if (nrsp.done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control counters and pipe valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      cnt_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (accept) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + 4'd1;
      end
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Corner factors: bit 0 of the corner picks x, bit 1 y, bit 2 z
  always_comb begin
    ax = cnt_r[0] ? {1'b0, fx_r} : 17'h10000 - {1'b0, fx_r};
    ay = cnt_r[1] ? {1'b0, fy_r} : 17'h10000 - {1'b0, fy_r};
    az = cnt_r[2] ? {1'b0, fz_r} : 17'h10000 - {1'b0, fz_r};
    m2_rnd = m2_r + 49'h0_8000_0000;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r      <= in_ch.cell_x;
      y_r      <= in_ch.cell_y;
      z_r      <= in_ch.cell_z;
      fx_r     <= in_ch.frac_x;
      fy_r     <= in_ch.frac_y;
      fz_r     <= in_ch.frac_z;
      val_r    <= in_ch.particle_value;
      rd_idx_r <= cell_addr({1'b0, in_ch.cell_x}, {1'b0, in_ch.cell_y},
                            {1'b0, in_ch.cell_z});
      res_r <= '{status: (in_ch.func == FUNC_READ) ? (oob_rd ? STATUS_DROP : STATUS_DONE)
                                                   : (oob_sp ? STATUS_DROP : STATUS_DONE),
                 cell_sum: '0, cell_weight: '0, normalized: '0};
    end
    if (state_r == ST_RD_DATA) begin
      res_r.cell_sum    <= vrdata;
      res_r.cell_weight <= wrdata;
    end
    if (state_r == ST_NORM && nrsp.done) begin
      res_r.normalized <= nrsp.q;
    end
    if (load_out) begin
      out_r <= res_r;
    end
    // Stage 1: two factors multiplied, corner address
    m1_r <= ax * ay;
    az_r <= az;
    a1_r <= cell_addr({1'b0, x_r} + {5'b0, cnt_r[0]}, {1'b0, y_r} + {5'b0, cnt_r[1]},
                      {1'b0, z_r} + {5'b0, cnt_r[2]});
    // Stage 2: third factor, Q1.48 weight
    m2_r <= 49'(m1_r * az_r);
    a2_r <= a1_r;
    // Stage 3: round weight to Q1.16; its address goes to the memories
    w3_r <= m2_rnd[48:32];
    a3_r <= a2_r;
    // Stage 4: weighted value, memory data arrives alongside
    prod4_r <= 50'($signed({1'b0, w3_r}) * val_r);
    w4_r    <= w3_r;
    a4_r    <= a3_r;
  end

  // Write-back: round contribution to Q15.16 (ties up), add and saturate
  always_comb begin
    contrib_full = (51'(prod4_r) + 51'sd32768) >>> 16;
    vsum = 50'($signed(vrdata)) + 50'(contrib_full);
    wsum = {1'b0, wrdata} + (WGT_W + 1)'(w4_r);
    if (state_r == ST_CLEAR) begin
      we     = 1'b1;
      waddr  = clr_r;
      vwdata = '0;
      wwdata = '0;
    end else begin
      we    = v4_r;
      waddr = a4_r;
      if (vsum > 50'sh7FFF_FFFF_FFFF) begin
        vwdata = 48'h7FFF_FFFF_FFFF;
      end else if (vsum < -50'sh8000_0000_0000) begin
        vwdata = 48'h8000_0000_0000;
      end else begin
        vwdata = vsum[SUM_W-1:0];
      end
      wwdata = wsum[WGT_W] ? {WGT_W{1'b1}} : wsum[WGT_W-1:0];
    end
    raddr = (state_r == ST_SPLAT) ? a3_r : rd_idx_r;
  end

  tgs_ram #(.WIDTH(SUM_W), .DEPTH(CELLS)) u_value_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (vwdata),
    .raddr (raddr),
    .rdata (vrdata)
  );

  tgs_ram #(.WIDTH(WGT_W), .DEPTH(CELLS)) u_weight_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wwdata),
    .raddr (raddr),
    .rdata (wrdata)
  );

  assign nreq.start = (state_r == ST_RD_DATA);
  assign nreq.sum   = vrdata;
  assign nreq.wgt   = wrdata;

  tgs_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nreq),
    .rsp   (nrsp)
  );

  // Output register holds the result until transferred
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.cell_sum    = out_r.cell_sum;
  assign out_ch.cell_weight = out_r.cell_weight;
  assign out_ch.normalized  = out_r.normalized;

endmodule

@@ tb/sv/trilinear_grid_splat_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for trilinear_grid_splat_top: drives splat and read
// transfers, predicts each result in place and compares field by field.
// Depends on tgs_pkg, tgs_if and the block's RTL.
module trilinear_grid_splat_top_tb;
  import tgs_pkg::*;

  localparam int GX = 32;
  localparam int GY = 32;
  localparam int GZ = 32;
  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam longint unsigned WGT_LIMIT = 64'h0000_00FF_FFFF_FFFF;

  typedef struct {
    logic                    func;
    logic [IDX_W-1:0]        cx;
    logic [IDX_W-1:0]        cy;
    logic [IDX_W-1:0]        cz;
    logic [FRAC_W-1:0]       fx;
    logic [FRAC_W-1:0]       fy;
    logic [FRAC_W-1:0]       fz;
    logic signed [VAL_W-1:0] pval;
  } grid_op_t;

  logic clk;
  logic rst_n;

  tgs_in_if  in_ch ();
  tgs_out_if out_ch ();

  trilinear_grid_splat_top #(.GRID_X(GX), .GRID_Y(GY), .GRID_Z(GZ)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the grid; absent entries read as the cleared value.
  longint          cell_sum_mem[int];
  longint unsigned cell_wgt_mem[int];
  result_t         cell_results[$];
  int              fail_count = 0;
  bit              no_idle = 0;
  int              hold_left = 0;
  int              stall_left = 0;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Hard stop in case the block hangs; clearing pass and all items fit well inside.
  initial begin
    #20ms;
    $display("** trilinear_grid_splat_top: FAILED **");
    $finish;
  end

  function automatic int cell_addr(int x, int y, int z);
    return (z * GY + y) * GX + x;
  endfunction

  // Sum divided by weight in Q15.16, truncated toward zero and saturated.
  function automatic logic signed [NORM_W-1:0] ratio_q16(longint s, longint unsigned w);
    longint unsigned mag;
    longint unsigned q;
    if (s == 0) return '0;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    q = (w == 0) ? (64'd1 << 32) : ((mag << 16) / w);
    if (s < 0) return (q >= (64'd1 << 31)) ? 32'sh8000_0000 : -$signed(q[31:0]);
    return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
  endfunction

  // Update the shadow grid and return the result the block owes for this transfer.
  function automatic result_t splat_or_read(grid_op_t op);
    result_t r;
    longint unsigned ax[2], ay[2], az[2];
    longint unsigned w;
    longint val, prod, contrib, s;
    longint unsigned ws;
    int a;
    r = '0;
    if (op.func == FUNC_READ) begin
      if (op.cx >= GX || op.cy >= GY || op.cz >= GZ) begin
        r.status = STATUS_DROP;
        return r;
      end
      a = cell_addr(op.cx, op.cy, op.cz);
      s  = cell_sum_mem.exists(a) ? cell_sum_mem[a] : 0;
      ws = cell_wgt_mem.exists(a) ? cell_wgt_mem[a] : 0;
      r.cell_sum    = s[SUM_W-1:0];
      r.cell_weight = ws[WGT_W-1:0];
      r.normalized  = ratio_q16(s, ws);
      return r;
    end
    // Drop when the upper corner leaves the grid.
    if (op.cx + 1 >= GX || op.cy + 1 >= GY || op.cz + 1 >= GZ) begin
      r.status = STATUS_DROP;
      return r;
    end
    val = op.pval;
    ax[0] = 65536 - op.fx; ax[1] = op.fx;
    ay[0] = 65536 - op.fy; ay[1] = op.fy;
    az[0] = 65536 - op.fz; az[1] = op.fz;
    for (int c = 0; c < 8; c++) begin
      a = cell_addr(op.cx + c[0], op.cy + c[1], op.cz + c[2]);
      w = (ax[c[0]] * ay[c[1]] * az[c[2]] + (64'd1 << 31)) >> 32;
      prod = longint'(w) * val;
      contrib = (prod + 32768) >>> 16;
      s = (cell_sum_mem.exists(a) ? cell_sum_mem[a] : 0) + contrib;
      if (s > SUM_MAX) s = SUM_MAX;
      if (s < SUM_MIN) s = SUM_MIN;
      cell_sum_mem[a] = s;
      ws = (cell_wgt_mem.exists(a) ? cell_wgt_mem[a] : 0) + w;
      if (ws > WGT_LIMIT) ws = WGT_LIMIT;
      cell_wgt_mem[a] = ws;
    end
    return r;
  endfunction

  // Offer one item, wait for the transfer, then queue its prediction.
  // Valid drops only inside an idle gap, so back-to-back items never
  // lower and raise it in the same step.
  task automatic send_op(grid_op_t op);
    int gap;
    result_t pred;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.func           <= op.func;
    in_ch.cell_x         <= op.cx;
    in_ch.cell_y         <= op.cy;
    in_ch.cell_z         <= op.cz;
    in_ch.frac_x         <= op.fx;
    in_ch.frac_y         <= op.fy;
    in_ch.frac_z         <= op.fz;
    in_ch.particle_value <= op.pval;
    do @(posedge clk); while (!in_ch.ready);
    pred = splat_or_read(op);
    cell_results.insert(cell_results.size(), pred);
  endtask

  function automatic grid_op_t make_op(logic f, int x, int y, int z,
                                       int fx, int fy, int fz, logic [31:0] v);
    grid_op_t op;
    op.func = f; op.cx = IDX_W'(x); op.cy = IDX_W'(y); op.cz = IDX_W'(z);
    op.fx = FRAC_W'(fx); op.fy = FRAC_W'(fy); op.fz = FRAC_W'(fz); op.pval = v;
    return op;
  endfunction

  // Stop offering and wait until every expected result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (cell_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Result side: random stall bursts, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_idle && rst_n && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (cell_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        exp_r = cell_results.pop_front();
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.cell_sum !== exp_r.cell_sum) begin
          $error("cell_sum: expected %0d, got %0d", exp_r.cell_sum, out_ch.cell_sum);
          fail_count++;
        end
        if (out_ch.cell_weight !== exp_r.cell_weight) begin
          $error("cell_weight: expected %0d, got %0d", exp_r.cell_weight,
                 out_ch.cell_weight);
          fail_count++;
        end
        if (out_ch.normalized !== exp_r.normalized) begin
          $error("normalized: expected %0d, got %0d", exp_r.normalized,
                 out_ch.normalized);
          fail_count++;
        end
      end
    end
  end

  // Field extremes: zero and full fractions, largest and smallest values,
  // the far corner of the grid, then read back the cells at both corners.
  task automatic test_extremes();
    send_op(make_op(FUNC_SPLAT, 0, 0, 0, 0, 0, 0, 32'h0001_0000));
    send_op(make_op(FUNC_SPLAT, 0, 0, 0, 65535, 65535, 65535, 32'h7FFF_FFFF));
    send_op(make_op(FUNC_SPLAT, 30, 30, 30, 32768, 32768, 32768, 32'h8000_0000));
    send_op(make_op(FUNC_SPLAT, 1, 2, 3, 12345, 54321, 4660, 32'hFFFF_FFFF));
    for (int c = 0; c < 8; c++) begin
      send_op(make_op(FUNC_READ, c[0], c[1], c[2], 0, 0, 0, 0));
      send_op(make_op(FUNC_READ, 30 + c[0], 30 + c[1], 30 + c[2], 65535, 65535,
                      65535, 32'hFFFF_FFFF));
    end
    send_op(make_op(FUNC_READ, 31, 31, 31, 0, 0, 0, 0));
    send_op(make_op(FUNC_READ, 17, 9, 25, 0, 0, 0, 0));  // never written
    wait_drained();
  endtask

  // Splats whose upper corner leaves the grid are dropped and leave no trace.
  task automatic test_out_of_grid();
    send_op(make_op(FUNC_SPLAT, 31, 5, 5, 100, 200, 300, 32'h0004_0000));
    send_op(make_op(FUNC_SPLAT, 5, 31, 5, 100, 200, 300, 32'h0004_0000));
    send_op(make_op(FUNC_SPLAT, 5, 5, 31, 100, 200, 300, 32'h0004_0000));
    send_op(make_op(FUNC_SPLAT, 31, 31, 31, 100, 200, 300, 32'h0004_0000));
    send_op(make_op(FUNC_READ, 5, 5, 5, 0, 0, 0, 0));
    send_op(make_op(FUNC_READ, 31, 5, 5, 0, 0, 0, 0));
    wait_drained();
  endtask

  // A corner weight of one with an extreme value pushes the ratio to the
  // saturation limits in both directions.
  task automatic test_ratio_saturation();
    send_op(make_op(FUNC_SPLAT, 10, 10, 10, 65535, 0, 0, 32'h7FFF_FFFF));
    send_op(make_op(FUNC_READ, 10, 10, 10, 0, 0, 0, 0));
    send_op(make_op(FUNC_SPLAT, 20, 10, 10, 65535, 0, 0, 32'h8000_0000));
    send_op(make_op(FUNC_READ, 20, 10, 10, 0, 0, 0, 0));
    // Cancel the sum back to zero while weight stays nonzero.
    send_op(make_op(FUNC_SPLAT, 3, 20, 3, 0, 0, 0, 32'h0002_0000));
    send_op(make_op(FUNC_SPLAT, 3, 20, 3, 0, 0, 0, 32'hFFFE_0000));
    send_op(make_op(FUNC_READ, 3, 20, 3, 0, 0, 0, 0));
    wait_drained();
  endtask

  // Random mix, mostly clustered on a few small regions so reads see
  // accumulated cells; the rest spans the full index range.
  function automatic grid_op_t random_op();
    grid_op_t op;
    int base;
    op.func = ($urandom_range(0, 9) < 3) ? FUNC_READ : FUNC_SPLAT;
    if ($urandom_range(0, 3) != 0) begin
      base = $urandom_range(0, 3) * 8;
      op.cx = IDX_W'(base + $urandom_range(0, 3));
      op.cy = IDX_W'(base + $urandom_range(0, 3));
      op.cz = IDX_W'(base + $urandom_range(0, 3));
    end else begin
      op.cx = IDX_W'($urandom_range(0, 31));
      op.cy = IDX_W'($urandom_range(0, 31));
      op.cz = IDX_W'($urandom_range(0, 31));
    end
    op.fx = FRAC_W'($urandom_range(0, 65535));
    op.fy = FRAC_W'($urandom_range(0, 65535));
    op.fz = FRAC_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0:       op.pval = VAL_W'($urandom_range(0, 1 << 20) - (1 << 19));
      default: op.pval = $urandom;
    endcase
    return op;
  endfunction

  task automatic test_random(int count);
    repeat (count) send_op(random_op());
  endtask

  // Hold the result side off long enough that the block stops taking input.
  task automatic test_backpressure();
    hold_left <= 800;
    test_random(40);
    wait_drained();
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.func           <= FUNC_SPLAT;
    in_ch.cell_x         <= '0;
    in_ch.cell_y         <= '0;
    in_ch.cell_z         <= '0;
    in_ch.frac_x         <= '0;
    in_ch.frac_y         <= '0;
    in_ch.frac_z         <= '0;
    in_ch.particle_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_out_of_grid();
    test_ratio_saturation();
    test_random(800);
    test_backpressure();   // also pauses the sender until all results are in
    test_random(800);
    no_idle = 1;
    test_random(300);
    wait_drained();

    if (fail_count == 0) begin
      $display("** trilinear_grid_splat_top: PASSED **");
    end else begin
      $display("** trilinear_grid_splat_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/tgs_pkg.sv
hdl/tgs_if.sv
hdl/tgs_ram.sv
hdl/tgs_norm.sv
hdl/trilinear_grid_splat_top.sv
tb/sv/trilinear_grid_splat_top_tb.sv
